// File: hw/rtl/rrsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin server pick package
// Field widths, function codes, verdict codes, the service entry layout,
// the sequencer states and the round-robin step function.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    localparam int DEF_NUM_SERVICES = 16;
    localparam int DEF_NUM_SERVERS  = 64;

    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 32;
    localparam int PORT_W   = 16;
    localparam int SRV_W    = 6;
    localparam int SVCI_W   = 4;
    localparam int PTR_W    = 7;
    localparam int MARK_W   = 7;

    localparam logic [FUNC_W-1:0] FUNC_PICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd2;

    localparam logic VERDICT_REPEAT = 1'b0;
    localparam logic VERDICT_DROP   = 1'b1;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [SRV_W-1:0]  first;
        logic [SRV_W-1:0]  last;
        logic [PTR_W-1:0]  ptr;
    } svc_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SVC_RD,
        ST_SVC_CHK,
        ST_SCAN,
        ST_RESULT
    } state_t;

    function automatic logic [SRV_W-1:0] next_server(
        input logic [SRV_W-1:0] cur,
        input logic [SRV_W-1:0] first,
        input logic [SRV_W-1:0] last
    );
        logic [SRV_W-1:0] nxt;
        nxt = (cur >= last) ? first : cur + 1'b1;
        return nxt;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rrsp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rrsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/port_round_robin_server_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Port round-robin server pick
// Service table and server status in two RAMs; a sequencer searches the
// service table for a port and scans the server range round robin.
//
//   Channel | Direction | Handshake          | Carries
//   in      | input     | in_valid/in_stall  | pick, status write, service write
//   out     | output    | out_valid/out_stall| packet_tag, verdict, mark
//
// Status and service writes are done in the idle state without leaving it.
// A pick reads the service entries in turn until one is valid and matches the
// port, then scans that service's server range for a server that is up, and
// hands the verdict to the result state; with no match it drops the packet.
// The rate is set by the one read port of each RAM: one entry per cycle.
// After reset a clearing pass marks all servers down in turn.
// The result waits in an output register; a stalled output holds a new pick.
// ----------------------------------------------------------------------------
module port_round_robin_server_pick #(
    parameter int NUM_SERVICES = rrsp_pkg::DEF_NUM_SERVICES,
    parameter int NUM_SERVERS  = rrsp_pkg::DEF_NUM_SERVERS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rrsp_pkg::FUNC_W-1:0]   func,
    input  wire logic [rrsp_pkg::TAG_W-1:0]    pkt_id,
    input  wire logic [rrsp_pkg::PORT_W-1:0]   dst_port,
    input  wire logic                          already_marked,
    input  wire logic [rrsp_pkg::SRV_W-1:0]    server_index,
    input  wire logic                          server_up,
    input  wire logic [rrsp_pkg::SVCI_W-1:0]   svc_slot,
    input  wire logic [rrsp_pkg::PORT_W-1:0]   service_port,
    input  wire logic [rrsp_pkg::SRV_W-1:0]    first_server,
    input  wire logic [rrsp_pkg::SRV_W-1:0]    last_server,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rrsp_pkg::TAG_W-1:0]    packet_tag,
    output logic                               verdict,
    output logic      [rrsp_pkg::MARK_W-1:0]   mark
);

    import rrsp_pkg::*;

    localparam int SVC_AW = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;
    localparam int SRV_AW = $clog2(NUM_SERVERS);
    localparam int SVC_EW = $bits(svc_entry_t);

    state_t                state_reg, state_next;
    logic [SRV_AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [NUM_SERVICES-1:0] svc_valid_reg, svc_valid_next;
    logic [SVC_AW-1:0]     svc_cnt_reg, svc_cnt_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [PORT_W-1:0]     port_reg, port_next;
    svc_entry_t            hit_entry_reg, hit_entry_next;
    logic [SVC_AW-1:0]     hit_idx_reg, hit_idx_next;
    logic [SRV_W-1:0]      cand_reg, cand_next;
    logic [SRV_W-1:0]      chk_reg, chk_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic                  chk_inr_reg, chk_inr_next;
    logic [SRV_W:0]        remain_reg, remain_next;
    logic                  res_verdict_reg, res_verdict_next;
    logic [MARK_W-1:0]     res_mark_reg, res_mark_next;
    logic                  out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]      out_tag_reg;
    logic                  out_verdict_reg;
    logic [MARK_W-1:0]     out_mark_reg;
    logic                  out_load;

    logic                  svc_we;
    logic [SVC_AW-1:0]     svc_waddr;
    svc_entry_t            svc_wdata;
    logic [SVC_AW-1:0]     svc_raddr;
    logic [SVC_EW-1:0]     svc_rdata;
    svc_entry_t            rd_entry;

    logic                  al_we;
    logic [SRV_AW-1:0]     al_waddr;
    logic [0:0]            al_wdata;
    logic [SRV_AW-1:0]     al_raddr;
    logic [0:0]            al_rdata;

    logic [SRV_W-1:0]      rd_last_eff;
    logic [SRV_W-1:0]      rd_cur;
    logic [SRV_W-1:0]      hit_last_eff;
    logic                  svc_match;
    logic                  svc_is_last;
    logic                  scan_hit;

    rrsp_ram #(
        .WIDTH (SVC_EW),
        .DEPTH (NUM_SERVICES)
    ) u_svc_ram (
        .clk   (clk),
        .we    (svc_we),
        .waddr (svc_waddr),
        .wdata (svc_wdata),
        .raddr (svc_raddr),
        .rdata (svc_rdata)
    );

    rrsp_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SERVERS)
    ) u_alive_ram (
        .clk   (clk),
        .we    (al_we),
        .waddr (al_waddr),
        .wdata (al_wdata),
        .raddr (al_raddr),
        .rdata (al_rdata)
    );

    assign rd_entry     = svc_entry_t'(svc_rdata);
    assign rd_last_eff  = (rd_entry.first > rd_entry.last) ? rd_entry.first : rd_entry.last;
    assign rd_cur       = ((rd_entry.ptr > {1'b0, rd_last_eff}) ||
                           (rd_entry.ptr < {1'b0, rd_entry.first}))
                          ? rd_entry.first : rd_entry.ptr[SRV_W-1:0];
    assign hit_last_eff = (hit_entry_reg.first > hit_entry_reg.last)
                          ? hit_entry_reg.first : hit_entry_reg.last;
    assign svc_match    = svc_valid_reg[svc_cnt_reg] && (rd_entry.port == port_reg);
    assign svc_is_last  = (svc_cnt_reg == SVC_AW'(NUM_SERVICES - 1));
    assign scan_hit     = chk_valid_reg && chk_inr_reg && al_rdata[0];
    assign al_raddr     = SRV_AW'(cand_reg);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        svc_valid_next   = svc_valid_reg;
        svc_cnt_next     = svc_cnt_reg;
        tag_next         = tag_reg;
        port_next        = port_reg;
        hit_entry_next   = hit_entry_reg;
        hit_idx_next     = hit_idx_reg;
        cand_next        = cand_reg;
        chk_next         = chk_reg;
        chk_valid_next   = chk_valid_reg;
        chk_inr_next     = chk_inr_reg;
        remain_next      = remain_reg;
        res_verdict_next = res_verdict_reg;
        res_mark_next    = res_mark_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_load         = 1'b0;

        svc_we    = 1'b0;
        svc_waddr = SVC_AW'(svc_slot);
        svc_wdata = '{port: service_port, first: first_server, last: last_server,
                      ptr: PTR_W'({1'b0, first_server} + 7'd1)};
        svc_raddr = svc_cnt_reg;

        al_we     = 1'b0;
        al_waddr  = SRV_AW'(server_index);
        al_wdata  = server_up;

        unique case (state_reg)
            ST_CLEAR:
            begin
                al_we    = 1'b1;
                al_waddr = clr_cnt_reg;
                al_wdata = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SRV_AW'(NUM_SERVERS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_STATUS:
                        begin
                            al_we = (32'(server_index) < 32'(NUM_SERVERS));
                        end
                        FUNC_WRITE:
                        begin
                            if (32'(svc_slot) < 32'(NUM_SERVICES))
                            begin
                                svc_we = 1'b1;
                                svc_valid_next[SVC_AW'(svc_slot)] = 1'b1;
                            end
                        end
                        FUNC_PICK:
                        begin
                            if (!already_marked)
                            begin
                                tag_next     = pkt_id;
                                port_next    = dst_port;
                                svc_cnt_next = '0;
                                state_next   = ST_SVC_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SVC_RD:
            begin
                state_next = ST_SVC_CHK;
            end
            ST_SVC_CHK:
            begin
                svc_raddr = svc_cnt_reg + 1'b1;
                if (svc_match)
                begin
                    hit_entry_next = rd_entry;
                    hit_idx_next   = svc_cnt_reg;
                    cand_next      = next_server(rd_cur, rd_entry.first, rd_last_eff);
                    remain_next    = {1'b0, rd_last_eff - rd_entry.first} + 1'b1;
                    chk_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end
                else if (svc_is_last)
                begin
                    res_verdict_next = VERDICT_DROP;
                    res_mark_next    = '0;
                    state_next       = ST_RESULT;
                end
                else
                begin
                    svc_cnt_next = svc_cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    svc_we           = 1'b1;
                    svc_waddr        = hit_idx_reg;
                    svc_wdata        = hit_entry_reg;
                    svc_wdata.ptr    = {1'b0, chk_reg};
                    res_verdict_next = VERDICT_REPEAT;
                    res_mark_next    = {1'b0, chk_reg} + 1'b1;
                    chk_valid_next   = 1'b0;
                    state_next       = ST_RESULT;
                end
                else if (remain_reg == '0)
                begin
                    res_verdict_next = VERDICT_DROP;
                    res_mark_next    = '0;
                    chk_valid_next   = 1'b0;
                    state_next       = ST_RESULT;
                end
                else
                begin
                    chk_next       = cand_reg;
                    chk_valid_next = 1'b1;
                    chk_inr_next   = (32'(cand_reg) < 32'(NUM_SERVERS));
                    cand_next      = next_server(cand_reg, hit_entry_reg.first, hit_last_eff);
                    remain_next    = remain_reg - 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            svc_valid_reg <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            svc_valid_reg <= svc_valid_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        svc_cnt_reg     <= svc_cnt_next;
        tag_reg         <= tag_next;
        port_reg        <= port_next;
        hit_entry_reg   <= hit_entry_next;
        hit_idx_reg     <= hit_idx_next;
        cand_reg        <= cand_next;
        chk_reg         <= chk_next;
        chk_inr_reg     <= chk_inr_next;
        remain_reg      <= remain_next;
        res_verdict_reg <= res_verdict_next;
        res_mark_reg    <= res_mark_next;
        if (out_load)
        begin
            out_tag_reg     <= tag_reg;
            out_verdict_reg <= res_verdict_reg;
            out_mark_reg    <= res_mark_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign packet_tag = out_tag_reg;
    assign verdict    = out_verdict_reg;
    assign mark       = out_mark_reg;

    // A new result appears only when the sequencer leaves its result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("result shown without a finished pick");

    // A drop carries no mark and a repeat always carries one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_verdict_reg == VERDICT_DROP) == (out_mark_reg == '0)))
        else $error("verdict and mark disagree");

    // A chosen server always lies inside the server table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_verdict_reg == VERDICT_REPEAT))
        |-> (32'(out_mark_reg) <= 32'(NUM_SERVERS)))
        else $error("mark beyond the server table");

    // The pointer write-back only goes to a valid service entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (svc_we && (state_reg == ST_SCAN)) |-> svc_valid_reg[hit_idx_reg])
        else $error("pointer written to an invalid service");

    // The remaining scan count never grows during a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && $past(state_reg == ST_SCAN))
        |-> (remain_reg <= $past(remain_reg)))
        else $error("scan count grew during a scan");

endmodule
`default_nettype wire

// File: bench/port_round_robin_server_pick_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Port round-robin server pick testbench
// Drives service writes, server status writes and pick requests through the
// valid/stall input channel and checks every verdict against a behavioral
// model of the service table, the server up bits and the round-robin pointers.
// A short directed table covers reset state, extremes, marked packets, the
// unused function code, reversed and full ranges and shadowed services. The
// random part mixes well-formed table setup with picks on known ports, while
// both channels idle at random and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module port_round_robin_server_pick_tb;
    import rrsp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int N_SERVICES      = DEF_NUM_SERVICES;
    localparam int N_SERVERS       = DEF_NUM_SERVERS;
    localparam int RANDOM_REQUESTS = 1024;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 120;
    localparam int HOLD_CYCLES     = 600;
    localparam int POOL_SIZE       = 8;
    localparam int N_DIRECTED      = 26;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TAG_W-1:0]  pkt_id;
        logic [PORT_W-1:0] dst_port;
        logic              already_marked;
        logic [SRV_W-1:0]  server_index;
        logic              server_up;
        logic [SVCI_W-1:0] svc_slot;
        logic [PORT_W-1:0] service_port;
        logic [SRV_W-1:0]  first_server;
        logic [SRV_W-1:0]  last_server;
    } request_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              verdict;
        logic [MARK_W-1:0] mark;
    } verdict_t;

    typedef struct {
        int func;
        int pid;
        int dport;
        int marked;
        int srv;
        int up;
        int svci;
        int sport;
        int first;
        int last;
        int fixed;
        int has;
        int verd;
        int mrk;
    } directed_row_t;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{FUNC_PICK,   32'h0000_0000, 16'h0000, 0,  0, 0,  0, 16'h0000,  0,  0, 1, 1,
          VERDICT_DROP, 0},
        '{FUNC_PICK,   32'hFFFF_FFFF, 16'hFFFF, 0, 63, 1, 15, 16'hFFFF, 63, 63, 1, 1,
          VERDICT_DROP, 0},
        '{FUNC_PICK,   32'h1234_5678, 16'h0050, 1,  0, 0,  0, 16'h0000,  0,  0, 1, 0, 0, 0},
        '{FUNC_NONE,   32'hA5A5_A5A5, 16'h0050, 0, 63, 1, 15, 16'hFFFF, 63,  0, 1, 0, 0, 0},
        '{FUNC_WRITE,  32'h0000_0000, 16'h0000, 0,  0, 0,  0, 16'h0050,  0,  3, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0010, 16'h0050, 0,  0, 0,  0, 16'h0000,  0,  0, 1, 1,
          VERDICT_DROP, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0,  0, 1,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0,  2, 1,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0011, 16'h0050, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0012, 16'h0050, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0013, 16'h0050, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_WRITE,  32'h0000_0000, 16'h0000, 0,  0, 0, 15, 16'hFFFF, 63, 63, 0, 0, 0, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0, 63, 1,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0014, 16'hFFFF, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_WRITE,  32'h0000_0000, 16'h0000, 0,  0, 0,  1, 16'h01BB, 10,  5, 0, 0, 0, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0, 10, 1,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0015, 16'h01BB, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_WRITE,  32'h0000_0000, 16'h0000, 0,  0, 0,  2, 16'h0050, 20, 21, 0, 0, 0, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0, 20, 1,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0016, 16'h0050, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0017, 16'h0050, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_WRITE,  32'h0000_0000, 16'h0000, 0,  0, 0,  3, 16'h0000,  0, 63, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0018, 16'h0000, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_STATUS, 32'h0000_0000, 16'h0000, 0, 63, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0},
        '{FUNC_PICK,   32'h0000_0019, 16'hFFFF, 0,  0, 0,  0, 16'h0000,  0,  0, 0, 0, 0, 0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    request_t          drv           = '0;
    logic              drv_valid     = 1'b0;
    bit                drv_fixed     = 1'b0;
    bit                drv_fixed_has = 1'b0;
    logic              drv_fixed_verdict = 1'b0;
    logic [MARK_W-1:0] drv_fixed_mark    = '0;
    logic              out_stall     = 1'b0;

    logic              in_stall;
    logic              out_valid;
    logic [TAG_W-1:0]  packet_tag;
    logic              verdict;
    logic [MARK_W-1:0] mark;

    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count  = 0;

    logic [PORT_W-1:0] tbl_port  [N_SERVICES] = '{default: '0};
    logic [SRV_W-1:0]  tbl_first [N_SERVICES] = '{default: '0};
    logic [SRV_W-1:0]  tbl_last  [N_SERVICES] = '{default: '0};
    bit                tbl_valid [N_SERVICES] = '{default: 1'b0};
    logic [PTR_W-1:0]  tbl_ptr   [N_SERVICES] = '{default: '0};
    bit                srv_alive [N_SERVERS]  = '{default: 1'b0};
    logic [PORT_W-1:0] port_pool [POOL_SIZE];

    verdict_t pending_verdicts [$];

    always #1 clk = ~clk;

    port_round_robin_server_pick i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (drv_valid),
        .in_stall       (in_stall),
        .func           (drv.func),
        .pkt_id         (drv.pkt_id),
        .dst_port       (drv.dst_port),
        .already_marked (drv.already_marked),
        .server_index   (drv.server_index),
        .server_up      (drv.server_up),
        .svc_slot       (drv.svc_slot),
        .service_port   (drv.service_port),
        .first_server   (drv.first_server),
        .last_server    (drv.last_server),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .packet_tag     (packet_tag),
        .verdict        (verdict),
        .mark           (mark)
    );

    function automatic bit serve_request(input request_t r, output verdict_t v);
        int  svc;
        int  first;
        int  last;
        int  cur;
        int  span;
        bit  matched;
        bit  picked;
        v.tag     = r.pkt_id;
        v.verdict = VERDICT_DROP;
        v.mark    = '0;
        if (r.func == FUNC_STATUS)
        begin
            srv_alive[r.server_index] = r.server_up;
            return 1'b0;
        end
        if (r.func == FUNC_WRITE)
        begin
            tbl_port[r.svc_slot]  = r.service_port;
            tbl_first[r.svc_slot] = r.first_server;
            tbl_last[r.svc_slot]  = r.last_server;
            tbl_valid[r.svc_slot] = 1'b1;
            tbl_ptr[r.svc_slot]   = PTR_W'(int'(r.first_server) + 1);
            return 1'b0;
        end
        if (r.func != FUNC_PICK || r.already_marked)
            return 1'b0;
        matched = 1'b0;
        svc = 0;
        for (int s = 0; s < N_SERVICES; s++)
        begin
            if (!matched && tbl_valid[s] && tbl_port[s] == r.dst_port)
            begin
                matched = 1'b1;
                svc = s;
            end
        end
        if (matched)
        begin
            first = int'(tbl_first[svc]);
            last  = int'(tbl_last[svc]);
            if (first > last)
                last = first;
            cur = int'(tbl_ptr[svc]);
            if (cur > last || cur < first)
                cur = first;
            span = last - first + 1;
            picked = 1'b0;
            for (int k = 0; k < span && !picked; k++)
            begin
                cur = (cur >= last) ? first : cur + 1;
                if (srv_alive[cur])
                begin
                    picked = 1'b1;
                    tbl_ptr[svc] = PTR_W'(cur);
                    v.verdict = VERDICT_REPEAT;
                    v.mark = MARK_W'(cur + 1);
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       sel;
        r.func           = FUNC_W'($urandom);
        r.pkt_id         = $urandom;
        r.dst_port       = PORT_W'($urandom);
        r.already_marked = 1'($urandom);
        r.server_index   = SRV_W'($urandom);
        r.server_up      = 1'($urandom);
        r.svc_slot       = SVCI_W'($urandom);
        r.service_port   = PORT_W'($urandom);
        r.first_server   = SRV_W'($urandom);
        r.last_server    = SRV_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 3)
            r.func = FUNC_NONE;
        else if (sel < 13)
        begin
            r.func = FUNC_WRITE;
            if ($urandom_range(9) != 0)
                r.service_port = port_pool[$urandom_range(POOL_SIZE - 1)];
            case ($urandom_range(9))
                0: ;
                1:
                begin
                    r.first_server = '0;
                    r.last_server  = '1;
                end
                default:
                    r.last_server = (r.first_server > 6'd56) ? 6'd63 :
                                    r.first_server + SRV_W'($urandom_range(7));
            endcase
        end
        else if (sel < 38)
        begin
            r.func = FUNC_STATUS;
            r.server_up = ($urandom_range(99) < 65);
        end
        else
        begin
            r.func = FUNC_PICK;
            r.already_marked = ($urandom_range(99) < 8);
            if ($urandom_range(99) < 85)
                r.dst_port = port_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return r;
    endfunction

    task automatic send_request(input request_t r, input bit fixed, input bit has,
                                input logic verd, input logic [MARK_W-1:0] mrk);
        while (!calm && $urandom_range(99) < 35)
        begin
            drv_valid <= 1'b0;
            @(posedge clk);
        end
        drv               <= r;
        drv_valid         <= 1'b1;
        drv_fixed         <= fixed;
        drv_fixed_has     <= has;
        drv_fixed_verdict <= verd;
        drv_fixed_mark    <= mrk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 35);
    end

    always @(posedge clk)
    begin : check_verdicts
        verdict_t got;
        verdict_t want;
        verdict_t predicted;
        bit       produces;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {packet_tag, verdict, mark};
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got tag %h verdict %0d mark %0d",
                             $time, got.tag, got.verdict, got.mark);
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.tag !== want.tag)
                    begin
                        $display("%0t: packet_tag mismatch: expected %h, actual %h",
                                 $time, want.tag, got.tag);
                        fail_count++;
                    end
                    if (got.verdict !== want.verdict)
                    begin
                        $display("%0t: verdict mismatch for tag %h: expected %0d, actual %0d",
                                 $time, want.tag, want.verdict, got.verdict);
                        fail_count++;
                    end
                    if (got.mark !== want.mark)
                    begin
                        $display("%0t: mark mismatch for tag %h: expected %0d, actual %0d",
                                 $time, want.tag, want.mark, got.mark);
                        fail_count++;
                    end
                end
            end
            if (drv_valid && !in_stall)
            begin
                produces = serve_request(drv, predicted);
                if (drv_fixed)
                begin
                    produces  = drv_fixed_has;
                    predicted = {drv.pkt_id, drv_fixed_verdict, drv_fixed_mark};
                end
                if (produces)
                    pending_verdicts.push_back(predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        request_t      req;
        directed_row_t row;
        int            counted;
        for (int i = 0; i < POOL_SIZE; i++)
            port_pool[i] = PORT_W'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            req.func           = FUNC_W'(row.func);
            req.pkt_id         = TAG_W'(row.pid);
            req.dst_port       = PORT_W'(row.dport);
            req.already_marked = 1'(row.marked);
            req.server_index   = SRV_W'(row.srv);
            req.server_up      = 1'(row.up);
            req.svc_slot       = SVCI_W'(row.svci);
            req.service_port   = PORT_W'(row.sport);
            req.first_server   = SRV_W'(row.first);
            req.last_server    = SRV_W'(row.last);
            send_request(req, row.fixed != 0, row.has != 0, 1'(row.verd), MARK_W'(row.mrk));
        end

        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (counted == 200)
                calm <= 1'b1;
            if (counted == 400)
                calm <= 1'b0;
            if (counted == 600)
                hold_req <= 1'b1;
            req = random_request();
            send_request(req, 1'b0, 1'b0, 1'b0, '0);
            counted++;
        end
        drv_valid <= 1'b0;

        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
